// ===== rtl/core/contour_limb_extremity_locator_defines.svh =====
// Assertion macros for the contour limb extremity locator.
// Included by modules that carry concurrent checks.
`ifndef CONTOUR_LIMB_EXTREMITY_LOCATOR_DEFINES_SVH
`define CONTOUR_LIMB_EXTREMITY_LOCATOR_DEFINES_SVH
`ifndef SYNTHESIS
`define CLE_ASSERT(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define CLE_ASSERT_NORST(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define CLE_ASSERT(label, clk, rst, prop, msg)
`define CLE_ASSERT_NORST(label, clk, prop, msg)
`endif
`endif

// ===== rtl/core/cle_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants for the contour limb extremity locator.
// No dependencies.
package cle_pkg;
  localparam int unsigned COORD_BITS = 11;
  localparam int unsigned OUT_W      = 11;
  localparam int unsigned MARGIN_W   = 8;
  localparam int unsigned KIND_W     = 3;

  typedef enum logic [2:0] {
    KIND_CENTROID = 3'd0,
    KIND_HEAD     = 3'd1,
    KIND_LHAND    = 3'd2,
    KIND_RHAND    = 3'd3,
    KIND_LLEG     = 3'd4,
    KIND_RLEG     = 3'd5
  } kind_t;

  typedef enum logic [3:0] {
    ST_LOAD,
    ST_DIV,
    ST_SCAN_RD,
    ST_SCAN_EV,
    ST_SCAN_HQ,
    ST_SCAN_SC,
    ST_EMIT,
    ST_CLEAR
  } state_t;

  typedef struct packed {
    logic load;      // store accepted point
    logic div_start;
    logic scan_init;
    logic rd_req;    // issue memory read
    logic eval;      // latch stored point
    logic hq_start;  // start head-score division
    logic score;     // update bests
    logic emit;      // result presented
    logic emit_next; // advance result index
    logic clear;
  } cmd_t;

  typedef struct packed {
    logic div_done;
    logic hq_done;
    logic scan_last;
    logic emit_last;
  } sts_t;
endpackage

// ===== rtl/core/cle_stream_if.sv =====
`timescale 1ns / 1ps
// Valid/ready stream interfaces for points and results.
// No dependencies.
interface cle_point_if;
  logic valid;
  logic ready;
  logic [10:0] pos_x;
  logic [10:0] pos_y;
  logic final_point;
  modport source (output valid, pos_x, pos_y, final_point, input ready);
  modport sink (input valid, pos_x, pos_y, final_point, output ready);
endinterface

interface cle_result_if;
  logic valid;
  logic ready;
  logic [2:0] kind;
  logic [10:0] out_x;
  logic [10:0] out_y;
  logic valid_res;
  logic overflowed;
  logic end_of_run;
  modport source (output valid, kind, out_x, out_y, valid_res, overflowed, end_of_run,
                  input ready);
  modport sink (input valid, kind, out_x, out_y, valid_res, overflowed, end_of_run,
                output ready);
endinterface

// ===== rtl/core/cle_ram.sv =====
`timescale 1ns / 1ps
// Generic single-port-write, single-port-read RAM with registered read.
// No dependencies.
module cle_ram #(
  parameter int unsigned WIDTH = 22,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

// ===== rtl/core/cle_divider.sv =====
`timescale 1ns / 1ps
// Restoring divider, one quotient bit per cycle, for the centroid and head score.
// No dependencies.
module cle_divider #(
  parameter int unsigned NW = 27,
  parameter int unsigned DW = 17
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  logic [NW-1:0] num,
  input  logic [DW-1:0] den,
  output logic [NW-1:0] quo,
  output logic          done
);
  localparam int unsigned CW = $clog2(NW + 1);
  logic [DW:0]   rem;
  logic [NW-1:0] q;
  logic [CW-1:0] cnt;
  logic          busy;
  logic [DW:0]   trial;

  always_comb begin
    trial = {rem[DW-1:0], q[NW-1]};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        rem  <= '0;
        q    <= num;
        cnt  <= CW'(NW);
      end else if (busy) begin
        if (trial >= {1'b0, den}) begin
          rem <= trial - {1'b0, den};
          q   <= {q[NW-2:0], 1'b1};
        end else begin
          rem <= trial;
          q   <= {q[NW-2:0], 1'b0};
        end
        cnt <= cnt - 1'b1;
        if (cnt == CW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end
  assign quo = q;
endmodule

// ===== rtl/core/cle_ctrl.sv =====
`timescale 1ns / 1ps
// Controller state machine for the contour limb extremity locator.
// Depends on cle_pkg and the defines header.
`include "contour_limb_extremity_locator_defines.svh"
module cle_ctrl
  import cle_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  input  logic in_final,
  output logic in_ready,
  input  logic out_valid,
  input  logic out_ready,
  input  sts_t sts,
  output cmd_t cmd
);
  state_t state, state_next;
  logic   div_wait, div_wait_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_LOAD;
      div_wait <= 1'b0;
    end else begin
      state    <= state_next;
      div_wait <= div_wait_next;
    end
  end

  always_comb begin
    state_next    = state;
    div_wait_next = div_wait;
    cmd           = '0;
    in_ready      = 1'b0;
    unique case (state)
      ST_LOAD: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load = 1'b1;
          if (in_final) begin
            state_next = ST_DIV;
          end
        end
      end
      ST_DIV: begin
        if (!div_wait) begin
          cmd.div_start = 1'b1;
          div_wait_next = 1'b1;
        end else if (sts.div_done) begin
          div_wait_next  = 1'b0;
          cmd.scan_init  = 1'b1;
          state_next     = ST_SCAN_RD;
        end
      end
      ST_SCAN_RD: begin
        if (sts.scan_last) begin
          state_next = ST_EMIT;
        end else begin
          cmd.rd_req = 1'b1;
          state_next = ST_SCAN_EV;
        end
      end
      ST_SCAN_EV: begin
        cmd.eval   = 1'b1;
        state_next = ST_SCAN_HQ;
      end
      ST_SCAN_HQ: begin
        if (!div_wait) begin
          cmd.hq_start  = 1'b1;
          div_wait_next = 1'b1;
        end else if (sts.hq_done) begin
          div_wait_next = 1'b0;
          state_next    = ST_SCAN_SC;
        end
      end
      ST_SCAN_SC: begin
        cmd.score  = 1'b1;
        state_next = ST_SCAN_RD;
      end
      ST_EMIT: begin
        cmd.emit = 1'b1;
        if (out_valid && out_ready) begin
          cmd.emit_next = 1'b1;
          if (sts.emit_last) begin
            state_next = ST_CLEAR;
          end
        end
      end
      ST_CLEAR: begin
        cmd.clear  = 1'b1;
        state_next = ST_LOAD;
      end
      default: state_next = ST_LOAD;
    endcase
  end

  `CLE_ASSERT(a_load_only_in_load, clk, rst, cmd.load |-> state == ST_LOAD, "load outside LOAD")
  `CLE_ASSERT(a_emit_then_clear, clk, rst,
    (cmd.emit_next && sts.emit_last) |=> state == ST_CLEAR, "no clear after last result")
  `CLE_ASSERT(a_no_accept_busy, clk, rst, in_ready |-> !out_valid, "accept while results pending")
endmodule

// ===== rtl/core/cle_datapath.sv =====
`timescale 1ns / 1ps
// Datapath: point store, sums, box, centroid divider, scoring and result mux.
// Depends on cle_pkg, cle_ram and cle_divider.
module cle_datapath
  import cle_pkg::*;
#(
  parameter int unsigned MAX_POINTS = 1024
) (
  input  logic                  clk,
  input  logic                  rst,
  input  cmd_t                  cmd,
  output sts_t                  sts,
  input  logic [OUT_W-1:0]      pos_x,
  input  logic [OUT_W-1:0]      pos_y,
  input  logic [MARGIN_W-1:0]   margin,
  output logic                  out_valid,
  output logic [KIND_W-1:0]     kind,
  output logic [OUT_W-1:0]      out_x,
  output logic [OUT_W-1:0]      out_y,
  output logic                  valid_res,
  output logic                  overflowed,
  output logic                  end_of_run
);
  localparam int unsigned AW = $clog2(MAX_POINTS);
  localparam int unsigned CNTW = $clog2(MAX_POINTS + 1);
  localparam int unsigned CB = COORD_BITS;
  localparam int unsigned SW = CB + CNTW;
  localparam int unsigned SCW = 2 * CB + 8;
  localparam logic [CB-1:0] CMAX = {CB{1'b1}};

  logic [CNTW-1:0] count, idx;
  logic [SW-1:0]   sum_x, sum_y;
  logic [CB-1:0]   min_x, min_y, max_x, max_y;
  logic            drop;
  logic [CB-1:0]   px, py;

  assign px = pos_x[CB-1:0];
  assign py = pos_y[CB-1:0];

  logic room;
  assign room = count < CNTW'(MAX_POINTS);

  always_ff @(posedge clk) begin
    if (rst || cmd.clear) begin
      count <= '0;
      sum_x <= '0;
      sum_y <= '0;
      min_x <= CMAX;
      min_y <= CMAX;
      max_x <= '0;
      max_y <= '0;
      drop  <= 1'b0;
    end else if (cmd.load) begin
      if (room) begin
        count <= count + 1'b1;
        sum_x <= sum_x + SW'(px);
        sum_y <= sum_y + SW'(py);
        if (px < min_x) min_x <= px;
        if (py < min_y) min_y <= py;
        if (px > max_x) max_x <= px;
        if (py > max_y) max_y <= py;
      end else begin
        drop <= 1'b1;
      end
    end
  end

  logic [2*CB-1:0] rdata;
  cle_ram #(.WIDTH(2 * CB), .DEPTH(MAX_POINTS)) u_store (
    .clk  (clk),
    .we   (cmd.load && room),
    .waddr(count[AW-1:0]),
    .wdata({py, px}),
    .raddr(idx[AW-1:0]),
    .rdata(rdata)
  );

  // centroid: one divider, x then y
  logic [SW-1:0] quo;
  logic          ddone;
  logic [SW-1:0] dnum;
  logic          dstart;
  logic [CB-1:0] cx, cy;
  logic          dphase;
  assign dnum = (ddone && !dphase) ? sum_y : sum_x;
  cle_divider #(.NW(SW), .DW(CNTW)) u_div (
    .clk(clk), .rst(rst), .start(dstart), .num(dnum),
    .den(count == '0 ? CNTW'(1) : count), .quo(quo), .done(ddone)
  );
  always_ff @(posedge clk) begin
    if (rst) begin
      dphase <= 1'b0;
    end else begin
      if (cmd.div_start) begin
        dphase <= 1'b0;
      end else if (ddone && !dphase) begin
        cx     <= (count == '0) ? '0 : quo[CB-1:0];
        dphase <= 1'b1;
      end else if (ddone && dphase) begin
        cy     <= (count == '0) ? '0 : quo[CB-1:0];
        dphase <= 1'b0;
      end
    end
  end
  assign dstart = cmd.div_start || (ddone && !dphase);
  assign sts.div_done = ddone && dphase;

  // scan
  logic [CB-1:0] qx, qy;
  logic          kept, any_kept, head_ok;
  logic [CB-1:0] adx, hq;
  logic          hdone;
  logic [2*CB-1:0] pen;
  logic signed [CB+1:0] dx, dy;
  logic signed [SCW-1:0] ex, ey, ex3, ey2, head_pen;
  logic signed [SCW-1:0] s [5];
  logic signed [SCW-1:0] best_s [5];
  logic [CB-1:0] best_x [5], best_y [5];

  assign sts.scan_last = (idx == count);

  // floor(|cx-qx|/cx) for the head score
  cle_divider #(.NW(CB), .DW(CB)) u_hdiv (
    .clk(clk), .rst(rst), .start(cmd.hq_start), .num(adx),
    .den(cx), .quo(hq), .done(hdone)
  );
  assign sts.hq_done = hdone;

  always_comb begin
    dx = $signed({2'b00, cx}) - $signed({2'b00, qx});
    dy = $signed({2'b00, cy}) - $signed({2'b00, qy});
    adx = (cx > qx) ? cx - qx : qx - cx;
    pen = cy * hq;
    head_pen = $signed(SCW'(pen));
    ex = SCW'(dx);
    ey = SCW'(dy);
    ex3 = ex + (ex <<< 1);
    ey2 = ey <<< 1;
    s[0] = ey + ey2 - (head_pen <<< 1);
    s[1] = ex3 + ey2;
    s[2] = ey2 - ex3;
    s[3] = ex3 - ey2;
    s[4] = -ex3 - ey2;
  end

  always_comb begin
    kept = ({1'b0, qx - min_x} < {1'b0, margin}) || ({1'b0, max_x - qx} < {1'b0, margin}) ||
           ({1'b0, qy - min_y} < {1'b0, margin}) || ({1'b0, max_y - qy} < {1'b0, margin});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      idx      <= '0;
      any_kept <= 1'b0;
    end else if (cmd.scan_init) begin
      idx      <= '0;
      any_kept <= 1'b0;
      for (int r = 0; r < 5; r++) begin
        best_s[r] <= '0;
        best_x[r] <= '0;
        best_y[r] <= '0;
      end
    end else begin
      if (cmd.rd_req) idx <= idx + 1'b1;
      if (cmd.eval) begin
        qx     <= rdata[CB-1:0];
        qy     <= rdata[2*CB-1:CB];
      end
      if (cmd.score && kept) begin
        any_kept <= 1'b1;
        for (int r = 0; r < 5; r++) begin
          if ((r != 0 || head_ok) && s[r] > best_s[r]) begin
            best_s[r] <= s[r];
            best_x[r] <= qx;
            best_y[r] <= qy;
          end else if (!any_kept) begin
            best_x[r] <= qx;
            best_y[r] <= qy;
          end
        end
      end
    end
  end
  assign head_ok = (cx != '0) && (cy != '0);

  // result emission
  logic [2:0] k;
  logic       ok;
  always_ff @(posedge clk) begin
    if (rst || cmd.clear) begin
      k <= 3'd0;
    end else if (cmd.emit_next) begin
      k <= k + 1'b1;
    end
  end

  assign out_valid = cmd.emit;
  always_comb begin
    ok = any_kept && (k != 3'(KIND_HEAD) || head_ok);
    kind = k;
    if (k == 3'(KIND_CENTROID)) begin
      out_x = OUT_W'(cx);
      out_y = OUT_W'(cy);
      valid_res = count != '0;
    end else begin
      out_x = ok ? OUT_W'(best_x[k - 1'b1]) : '0;
      out_y = ok ? OUT_W'(best_y[k - 1'b1]) : '0;
      valid_res = ok;
    end
    overflowed = drop;
    end_of_run = (k == 3'(KIND_RLEG));
  end
  assign sts.emit_last = (k == 3'(KIND_RLEG));
endmodule

// ===== rtl/core/contour_limb_extremity_locator.sv =====
`timescale 1ns / 1ps
// Top level of the contour limb extremity locator: controller, datapath, config.
// Depends on cle_pkg, the stream interfaces, cle_ctrl and cle_datapath.
// Points are taken one per cycle; after the final point the block computes the
// centroid with a bit-serial divider, x then y, then scans the stored points one
// at a time (read, capture, bit-serial head-score division, update), ends the
// scan, then presents six results, each held until transferred, and clears its
// state. No new point is taken until the sixth result is transferred.
module contour_limb_extremity_locator
  import cle_pkg::*;
#(
  parameter int unsigned MAX_POINTS = 1024
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_we,
  input  logic [MARGIN_W-1:0] cfg_wdata,
  cle_point_if.sink           points,
  cle_result_if.source        results
);
  logic [MARGIN_W-1:0] edge_margin;
  cmd_t cmd;
  sts_t sts;

  always_ff @(posedge clk) begin
    if (rst) edge_margin <= MARGIN_W'(4);
    else if (cfg_we) edge_margin <= cfg_wdata;
  end

  cle_ctrl u_ctrl (
    .clk(clk), .rst(rst),
    .in_valid(points.valid), .in_final(points.final_point), .in_ready(points.ready),
    .out_valid(results.valid), .out_ready(results.ready),
    .sts(sts), .cmd(cmd)
  );

  cle_datapath #(.MAX_POINTS(MAX_POINTS)) u_dp (
    .clk(clk), .rst(rst), .cmd(cmd), .sts(sts),
    .pos_x(points.pos_x), .pos_y(points.pos_y), .margin(edge_margin),
    .out_valid(results.valid), .kind(results.kind), .out_x(results.out_x),
    .out_y(results.out_y), .valid_res(results.valid_res),
    .overflowed(results.overflowed), .end_of_run(results.end_of_run)
  );
endmodule

// ===== dv/tb_top.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for contour_limb_extremity_locator: contours go in,
// centroid and limb points are predicted and checked against the result stream.
// Depends on cle_pkg, cle_stream_if.sv and the RTL of the block.
module tb_top
  import cle_pkg::*;
();

  localparam int CAPACITY = 1024;
  localparam int STALL_LIMIT = 100000;

  typedef struct {
    kind_t kind;
    logic [10:0] x;
    logic [10:0] y;
    logic valid_res;
    logic overflowed;
    logic end_of_run;
  } limb_res_t;

  class limb_scoreboard;
    limb_res_t pending_q[$];
    int unsigned xs[$];
    int unsigned ys[$];
    longint unsigned sx, sy;
    int unsigned min_x, min_y, max_x, max_y;
    bit dropped;
    int unsigned margin;
    int errors;

    function new();
      margin = 4;
      errors = 0;
      clear();
    endfunction

    function void clear();
      xs.delete();
      ys.delete();
      sx = 0;
      sy = 0;
      min_x = 2047;
      min_y = 2047;
      max_x = 0;
      max_y = 0;
      dropped = 0;
    endfunction

    function void push(int k, int unsigned x, int unsigned y, bit v);
      limb_res_t r;
      r.kind = kind_t'(k);
      r.x = x[10:0];
      r.y = y[10:0];
      r.valid_res = v;
      r.overflowed = dropped;
      r.end_of_run = (k == 5);
      pending_q.insert(pending_q.size(), r);
    endfunction

    function longint limb_score(int rule, longint cx, longint cy, longint px, longint py);
      longint adx;
      adx = (cx > px) ? cx - px : px - cx;
      case (rule)
        0: return 3 * (cy - py) - 2 * cy * (adx / cx);
        1: return 3 * (cx - px) + 2 * (cy - py);
        2: return 3 * (px - cx) + 2 * (cy - py);
        3: return 3 * (cx - px) + 2 * (py - cy);
        default: return 3 * (px - cx) + 2 * (py - cy);
      endcase
    endfunction

    function void note_point(int unsigned px, int unsigned py, bit last);
      int unsigned cx, cy, n;
      int unsigned bx[5], by[5];
      longint bs[5];
      longint s;
      bit any_kept, head_ok, kept, ok;
      cx = 0;
      cy = 0;
      any_kept = 0;
      if (xs.size() < CAPACITY) begin
        xs.insert(xs.size(), px);
        ys.insert(ys.size(), py);
        sx += px;
        sy += py;
        if (px < min_x) min_x = px;
        if (py < min_y) min_y = py;
        if (px > max_x) max_x = px;
        if (py > max_y) max_y = py;
      end else begin
        dropped = 1;
      end
      if (!last) return;
      n = xs.size();
      if (n != 0) begin
        cx = 32'(sx / n);
        cy = 32'(sy / n);
      end
      head_ok = (cx != 0) && (cy != 0);
      for (int r = 0; r < 5; r++) begin
        bx[r] = 0;
        by[r] = 0;
        bs[r] = 0;
      end
      for (int i = 0; i < n; i++) begin
        kept = (xs[i] - min_x < margin) || (max_x - xs[i] < margin) ||
               (ys[i] - min_y < margin) || (max_y - ys[i] < margin);
        if (!kept) continue;
        if (!any_kept) begin
          any_kept = 1;
          for (int r = 0; r < 5; r++) begin
            bx[r] = xs[i];
            by[r] = ys[i];
          end
        end
        for (int r = 0; r < 5; r++) begin
          if (r == 0 && !head_ok) continue;
          s = limb_score(r, cx, cy, xs[i], ys[i]);
          if (s > bs[r]) begin
            bs[r] = s;
            bx[r] = xs[i];
            by[r] = ys[i];
          end
        end
      end
      push(0, cx, cy, n != 0);
      for (int r = 0; r < 5; r++) begin
        ok = any_kept && (r != 0 || head_ok);
        push(r + 1, ok ? bx[r] : 0, ok ? by[r] : 0, ok);
      end
      clear();
    endfunction

    task report(string what);
      errors++;
      $display("mismatch: %s", what);
    endtask

    task check_result(logic [2:0] kind, logic [10:0] x, logic [10:0] y,
                      logic v, logic ov, logic eor);
      limb_res_t e;
      if (pending_q.size() == 0) begin
        report($sformatf("unexpected result kind %0d x %0d y %0d", kind, x, y));
        return;
      end
      e = pending_q.pop_front();
      if (kind !== e.kind || x !== e.x || y !== e.y || v !== e.valid_res ||
          ov !== e.overflowed || eor !== e.end_of_run)
        report($sformatf("kind %0d/%0d x %0d/%0d y %0d/%0d v %0d/%0d ov %0d/%0d eor %0d/%0d",
                         kind, e.kind, x, e.x, y, e.y, v, e.valid_res, ov, e.overflowed,
                         eor, e.end_of_run));
    endtask
  endclass

  logic clk;
  logic rst;
  logic cfg_we;
  logic [MARGIN_W-1:0] cfg_wdata;
  bit quiet;
  int idle_cycles;
  limb_scoreboard sb;

  cle_point_if points ();
  cle_result_if results ();

  contour_limb_extremity_locator uut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .points(points), .results(results)
  );

  initial begin
    clk = 0;
    forever #2 clk = ~clk;
  end

  // result sink with random stall bursts
  initial begin
    int hold;
    results.ready = 0;
    hold = 0;
    forever begin
      @(negedge clk);
      if (hold > 0) begin
        hold--;
        results.ready = 0;
      end else if (!quiet && $urandom_range(0, 5) == 0) begin
        hold = $urandom_range(0, 2);
        results.ready = 0;
      end else begin
        results.ready = 1;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && results.valid && results.ready)
      sb.check_result(results.kind, results.out_x, results.out_y, results.valid_res,
                      results.overflowed, results.end_of_run);
  end

  always @(posedge clk) begin
    if (rst || (points.valid && points.ready) || (results.valid && results.ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  task send_point(int unsigned x, int unsigned y, bit last);
    int gap;
    if (!quiet && $urandom_range(0, 4) == 0) begin
      gap = $urandom_range(1, 3);
      points.valid = 0;
      repeat (gap) @(negedge clk);
    end
    points.valid = 1;
    points.pos_x = x[10:0];
    points.pos_y = y[10:0];
    points.final_point = last;
    @(posedge clk);
    while (!points.ready) @(posedge clk);
    sb.note_point(x, y, last);
    @(negedge clk);
  endtask

  task wait_idle();
    points.valid = 0;
    while (sb.pending_q.size() != 0) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  task write_margin(int unsigned m);
    wait_idle();
    cfg_we = 1;
    cfg_wdata = m[7:0];
    @(negedge clk);
    cfg_we = 0;
    sb.margin = m;
  endtask

  task random_contour(int len);
    int unsigned bx, by, span;
    span = $urandom_range(0, 3) == 0 ? 2047 : $urandom_range(4, 300);
    bx = $urandom_range(0, 2047 - span);
    by = $urandom_range(0, 2047 - span);
    for (int i = 0; i < len; i++)
      send_point(bx + $urandom_range(0, span), by + $urandom_range(0, span), i == len - 1);
  endtask

  initial begin
    int sent;
    int len;
    int unsigned margins[6];
    sb = new();
    quiet = 0;
    idle_cycles = 0;
    cfg_we = 0;
    cfg_wdata = '0;
    points.valid = 0;
    points.pos_x = '0;
    points.pos_y = '0;
    points.final_point = 0;
    rst = 1;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst = 0;

    // directed: lone origin, box corners, x=0 and y=0 contours, lone max point
    send_point(0, 0, 1);
    send_point(0, 0, 0);
    send_point(2047, 2047, 0);
    send_point(0, 2047, 0);
    send_point(2047, 0, 0);
    send_point(1024, 1024, 1);
    send_point(0, 5, 0);
    send_point(0, 100, 1);
    send_point(7, 0, 0);
    send_point(9, 0, 1);
    send_point(2047, 2047, 1);
    send_point(100, 100, 0);
    send_point(500, 300, 0);
    send_point(300, 500, 0);
    send_point(300, 300, 1);
    write_margin(0);
    send_point(100, 200, 0);
    send_point(1500, 1800, 1);
    write_margin(255);
    send_point(1365, 682, 0);
    send_point(682, 1365, 0);
    send_point(1000, 1000, 1);

    margins[0] = 1;
    margins[1] = 4;
    margins[2] = $urandom_range(2, 254);
    margins[3] = 0;
    margins[4] = 255;
    margins[5] = $urandom_range(1, 40);
    sent = 0;
    for (int p = 0; p < 6; p++) begin
      write_margin(margins[p]);
      for (int k = 0; k < 3; k++) begin
        len = $urandom_range(0, 5) == 0 ? $urandom_range(10, 30) : $urandom_range(1, 6);
        random_contour(len);
        sent += len;
      end
    end
    write_margin(4);
    quiet = 1;
    while (sent < 120) begin
      len = $urandom_range(1, 8);
      random_contour(len);
      sent += len;
    end

    wait_idle();
    repeat (50) @(negedge clk);
    if (sb.errors == 0 && sb.pending_q.size() == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end
endmodule

// ===== contour_limb_extremity_locator.f =====
+incdir+rtl/core
rtl/core/cle_pkg.sv
rtl/core/cle_stream_if.sv
rtl/core/cle_ram.sv
rtl/core/cle_divider.sv
rtl/core/cle_ctrl.sv
rtl/core/cle_datapath.sv
rtl/core/contour_limb_extremity_locator.sv
dv/tb_top.sv
